>>> rtl/lpc_cfg_pkg.sv
package lpc_cfg_pkg;

  localparam logic [15:0] DEF_VENDOR_CODE = 16'd32902;
  localparam logic [15:0] DEF_PART_CODE   = 16'd9424;
  localparam logic [7:0]  DEF_REVISION_ID = 8'd2;
  localparam int          IRQ_COUNT       = 24;

  localparam logic [7:0] CLASS_SUB  = 8'h01;
  localparam logic [7:0] CLASS_BASE = 8'h06;

  localparam logic [2:0] OP_CFG_WR  = 3'd0;
  localparam logic [2:0] OP_CFG_RD  = 3'd1;
  localparam logic [2:0] OP_DEV_RST = 3'd2;
  localparam logic [2:0] OP_ROUTE   = 3'd3;
  localparam logic [2:0] OP_RP_WR   = 3'd4;
  localparam logic [2:0] OP_RP_RD   = 3'd5;

  localparam logic [7:0] ADDR_PMBASE_LO = 8'h40;
  localparam logic [7:0] ADDR_PMBASE_HI = 8'h41;
  localparam logic [7:0] ADDR_ACPI_CTL  = 8'h44;
  localparam logic [7:0] ADDR_GEN_CTL   = 8'hd1;
  localparam logic [7:0] ADDR_RTC_CONF  = 8'hd8;

  typedef struct packed {
    logic       wr;
    logic       sh;
    logic [7:0] val;
  } wr_byte_t;

  // per-address write mask, sticky bits and shadow flag
  function automatic wr_byte_t masked_byte(input logic [7:0] a, input logic [7:0] v,
                                           input logic [7:0] old);
    wr_byte_t r;
    r = '{wr: 1'b1, sh: 1'b0, val: 8'h00};
    unique case (a)
      8'h04: r.val = v & 8'h40;
      8'h05: r.val = v & 8'h01;
      8'h07: r.val = (v & 8'h06) | 8'h02;
      8'h40: begin r.sh = 1'b1; r.val = (v & 8'h80) | 8'h01; end
      8'h41: begin r.sh = 1'b1; r.val = v; end
      8'h44: begin r.sh = 1'b1; r.val = v & 8'h17; end
      8'h4e: r.val = v & 8'h03;
      8'h54: r.val = v & 8'h0f;
      8'h58: r.val = (v & 8'h80) | 8'h01;
      8'h5c: r.val = v & 8'h10;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h68, 8'h69, 8'h6a, 8'h6b: r.val = v & 8'h8f;
      8'h88: r.val = v & 8'h06;
      8'h8a: r.val = v & 8'hf9;
      8'h91: r.val = v & 8'hfc;
      8'ha0: begin r.sh = 1'b1; r.val = (v & 8'h3f) | (old & 8'h10); end
      8'ha2: begin r.sh = 1'b1; r.val = v & 8'h60; end
      8'ha4: begin r.sh = 1'b1; r.val = v & 8'hfc; end
      8'ha8: begin r.sh = 1'b1; r.val = v & 8'h3f; end
      8'had: begin r.sh = 1'b1; r.val = v & 8'h03; end
      8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8,
      8'hc9, 8'hca, 8'hcb, 8'hcc, 8'hcd: begin r.sh = 1'b1; r.val = v; end
      8'hc0: begin r.sh = 1'b1; r.val = v & 8'hf0; end
      8'hd0: r.val = v & 8'hc7;
      8'hd1: r.val = (v & 8'hbb) | (old & 8'h02);
      8'hd2: r.val = v & 8'h0f;
      8'hd3: r.val = v & 8'h03;
      8'hd4: r.val = v & 8'h02;
      8'hd5: r.val = v & 8'h2f;
      8'hd8: r.val = (v & 8'h1c) | (old & 8'h18);
      8'he0: r.val = v & 8'h77;
      8'he1: r.val = v & 8'h13;
      8'he4: r.val = v & 8'h01;
      8'he6: r.val = v & 8'h0f;
      8'he7: r.val = v & 8'h2f;
      8'hec: r.val = v & 8'hf1;
      8'hf0: r.val = v & 8'h0f;
      8'hf2: r.val = v & 8'h6f;
      8'hf3: r.val = v & 8'hcf;
      8'h59, 8'h64, 8'h90, 8'he3, 8'he5, 8'he8, 8'he9, 8'hea, 8'heb,
      8'hed, 8'hee, 8'hef: r.val = v;
      default: r.wr = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_shadowed(input logic [7:0] a);
    return (a == 8'h40) || (a == 8'h41) || (a == 8'h44) || (a[7:4] == 4'ha) ||
           (a[7:4] == 4'hc) || (a[7:2] == 6'b101110);
  endfunction

  // value a byte takes on a reset sweep; sh is the shadow copy
  function automatic logic [7:0] reset_byte(input logic [7:0] a, input logic [7:0] sh,
                                            input logic [15:0] vid, input logic [15:0] did,
                                            input logic [7:0] rev);
    logic [7:0] r;
    r = 8'h00;
    if (is_shadowed(a)) begin
      r = sh;
    end else begin
      unique case (a)
        8'h00: r = vid[7:0];
        8'h01: r = vid[15:8];
        8'h02: r = did[7:0];
        8'h03: r = did[15:8];
        8'h04: r = 8'h0f;
        8'h06: r = 8'h80;
        8'h07: r = 8'h02;
        8'h08: r = rev;
        8'h0a: r = CLASS_SUB;
        8'h0b: r = CLASS_BASE;
        8'h58: r = 8'h01;
        8'h60, 8'h61, 8'h62, 8'h63, 8'h68, 8'h69, 8'h6a, 8'h6b: r = 8'h80;
        8'h64: r = 8'h10;
        8'hd0: r = 8'h04;
        8'he3: r = 8'hff;
        8'he9: r = 8'h33;
        8'hea: r = 8'h22;
        8'heb: r = 8'h11;
        8'hee: r = 8'h78;
        8'hef: r = 8'h56;
        8'hf0: r = 8'h02;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

  function automatic logic [4:0] route_of(input logic [7:0] r, input logic [2:0] idx);
    logic ok;
    logic [4:0] irq;
    ok = (r[3:0] >= 4'd3 && r[3:0] <= 4'd7) || (r[3:0] >= 4'd9 && r[3:0] <= 4'd12) ||
         (r[3:0] == 4'd14) || (r[3:0] == 4'd15);
    irq = {1'b0, r[3:0]};
    if (r[7] || !ok) irq = 5'd16 + {2'b00, idx};
    if (irq >= 5'(IRQ_COUNT)) irq = 5'd0;
    return irq;
  endfunction

endpackage

>>> rtl/lpc_bridge_config_space_top.sv
// device reset: a sweep over all 256 config bytes
// requests are handled one at a time; in_ready is high again in the same cycle
// that the result appears on out_valid
// reset: synchronous; after rst the block runs a sweep loading identity bytes
// and defaults into the config store, with in_ready low until it ends
module lpc_bridge_config_space_top import lpc_cfg_pkg::*; #(
  parameter logic [15:0] VENDOR_CODE = DEF_VENDOR_CODE,
  parameter logic [15:0] PART_CODE   = DEF_PART_CODE,
  parameter logic [7:0]  REVISION_ID = DEF_REVISION_ID
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  address,
  input  logic [31:0] write_data,
  input  logic [2:0]  access_length,
  input  logic [2:0]  route_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [4:0]  route_irq,
  output logic [15:0] acpi_base,
  output logic        acpi_enabled,
  output logic [4:0]  sci_irq,
  output logic        upper_nvr_enabled,
  output logic        lower_nvr_locked,
  output logic        upper_nvr_locked,
  output logic        system_reset_request
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_XFER  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;

  logic [2:0] state;
  logic       por;

  // stores: config bytes and the power-management shadow (valid bits for the shadow)
  logic [7:0]   cfg_mem [256];
  logic [7:0]   sh_mem  [256];
  logic [255:0] sh_valid;
  logic [7:0]   cfg_q, sh_q;
  logic         sh_vq;

  // request registers
  logic [2:0]  op_q;
  logic [7:0]  addr_q;
  logic [31:0] data_q;
  logic [2:0]  len_q;
  logic [2:0]  idx_q;
  logic [2:0]  cnt;
  logic [8:0]  sw;
  logic [31:0] rd_acc;
  logic [7:0]  route_byte;

  // second stage of the read-modify-write pipe
  logic       p_valid;
  logic [7:0] p_addr;
  logic [1:0] p_pos;

  // copies of the bytes the side effects look at
  logic [7:0] m40, m41, m44, md1, md8;

  // architectural status
  logic [15:0] acpi_base_reg;
  logic        acpi_enable_reg;
  logic [4:0]  sci_irq_reg;
  logic        nvr_ue, nvr_ll, nvr_ul;
  logic        reset_type_bit;

  logic [8:0]  byte_a;
  logic        issue;
  logic        cfg_we, sh_we, rd_en;
  logic [7:0]  cfg_waddr, cfg_wdata, rd_addr;
  logic [7:0]  wr_in;
  wr_byte_t    mb;
  logic [7:0]  sw_sh;
  logic        fin_go;
  logic [15:0] acpi_base_next;
  logic        acpi_en_next;
  logic [4:0]  sci_next;
  logic        upd_acpi, upd_nvr;
  logic [2:0]  len_cap;
  logic [7:0]  route_addr;

  assign in_ready = (state == ST_IDLE);
  assign fin_go   = (state == ST_FIN) && (!out_valid || out_ready);

  // byte address of the next access; bytes past the top are dropped
  assign byte_a = {1'b0, addr_q} + {6'b0, cnt};
  assign issue  = (state == ST_XFER) && (cnt < len_q) && !byte_a[8];

  assign len_cap    = (access_length > 3'd4) ? 3'd4 : access_length;
  assign route_addr = (route_index > 3'd3) ? (8'h64 + {5'b0, route_index})
                                           : (8'h60 + {5'b0, route_index});

  assign wr_in = data_q[{p_pos, 3'b000} +: 8];
  assign mb    = masked_byte(p_addr, wr_in, cfg_q);
  assign sw_sh = sh_vq ? sh_q : 8'h00;

  // one write port, one read port per store
  always_comb begin
    cfg_we    = 1'b0;
    sh_we     = 1'b0;
    cfg_waddr = p_addr;
    cfg_wdata = mb.val;
    rd_en     = 1'b0;
    rd_addr   = byte_a[7:0];
    if (state == ST_SWEEP) begin
      rd_addr   = sw[7:0];
      rd_en     = !sw[8];
      cfg_wdata = reset_byte(p_addr, sw_sh, VENDOR_CODE, PART_CODE, REVISION_ID);
      // a device reset leaves the low header alone but for bytes 04h, 06h and 07h (command low byte and status)
      cfg_we    = p_valid && (por || p_addr >= 8'h40 || p_addr == 8'h04 ||
                              p_addr == 8'h06 || p_addr == 8'h07);
    end else if (state == ST_XFER) begin
      rd_en  = issue;
      cfg_we = p_valid && (op_q == OP_CFG_WR) && mb.wr;
      sh_we  = p_valid && (op_q == OP_CFG_WR) && mb.wr && mb.sh;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) cfg_mem[cfg_waddr] <= cfg_wdata;
    if (sh_we) sh_mem[p_addr] <= mb.val;
    if (rd_en) begin
      cfg_q <= cfg_mem[rd_addr];
      sh_q  <= sh_mem[rd_addr];
      sh_vq <= sh_valid[rd_addr];
    end
  end

  // derived ACPI state from the current control bytes
  always_comb begin
    acpi_base_next = {m41, m40[7], 7'b0};
    acpi_en_next   = m44[4];
    if (m44[2:0] == 3'd1 || m44[2:0] == 3'd2) begin
      sci_next = 5'd9 + {2'b0, m44[2:0]};
    end else if (m44[2] && md1[0]) begin
      sci_next = 5'd20 + {3'b0, m44[1:0]};
    end else begin
      sci_next = 5'd9;
    end
  end

  assign upd_acpi = (op_q == OP_DEV_RST) || ((op_q == OP_CFG_WR) &&
                    (addr_q == ADDR_PMBASE_LO || addr_q == ADDR_PMBASE_HI ||
                     addr_q == ADDR_ACPI_CTL));
  assign upd_nvr  = (op_q == OP_CFG_WR) && (addr_q == ADDR_RTC_CONF);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_SWEEP;
      por             <= 1'b1;
      sw              <= '0;
      p_valid         <= 1'b0;
      out_valid       <= 1'b0;
      sh_valid        <= '0;
      acpi_base_reg   <= '0;
      acpi_enable_reg <= 1'b0;
      sci_irq_reg     <= 5'd9;
      nvr_ue          <= 1'b0;
      nvr_ll          <= 1'b0;
      nvr_ul          <= 1'b0;
      reset_type_bit  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !fin_go) out_valid <= 1'b0;
      if (sh_we) sh_valid[p_addr] <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_waddr)
          ADDR_PMBASE_LO: m40 <= cfg_wdata;
          ADDR_PMBASE_HI: m41 <= cfg_wdata;
          ADDR_ACPI_CTL:  m44 <= cfg_wdata;
          ADDR_GEN_CTL:   md1 <= cfg_wdata;
          ADDR_RTC_CONF:  md8 <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q   <= opcode;
            data_q <= write_data;
            idx_q  <= route_index;
            cnt    <= '0;
            sw     <= '0;
            rd_acc <= '0;
            addr_q <= (opcode == OP_ROUTE) ? route_addr : address;
            priority if (opcode == OP_CFG_WR || opcode == OP_CFG_RD) begin
              len_q <= len_cap;
              state <= ST_XFER;
            end else if (opcode == OP_ROUTE) begin
              len_q <= 3'd1;
              state <= ST_XFER;
            end else if (opcode == OP_DEV_RST) begin
              len_q <= 3'd0;
              state <= ST_SWEEP;
            end else begin
              len_q <= 3'd0;
              state <= ST_FIN;
            end
          end
        end
        ST_XFER: begin
          p_valid <= issue;
          p_addr  <= byte_a[7:0];
          p_pos   <= cnt[1:0];
          if (issue) cnt <= cnt + 3'd1;
          if (p_valid) begin
            if (op_q == OP_CFG_RD) rd_acc <= rd_acc | ({24'b0, cfg_q} << {p_pos, 3'b000});
            if (op_q == OP_ROUTE) route_byte <= cfg_q;
          end
          if (!issue && !p_valid) state <= ST_FIN;
        end
        ST_SWEEP: begin
          p_valid <= !sw[8];
          p_addr  <= sw[7:0];
          if (!sw[8]) sw <= sw + 9'd1;
          if (sw[8] && !p_valid) begin
            por   <= 1'b0;
            state <= por ? ST_IDLE : ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            automatic logic [15:0] ab = acpi_base_reg;
            automatic logic        ae = acpi_enable_reg;
            automatic logic [4:0]  si = sci_irq_reg;
            automatic logic        ue = nvr_ue;
            automatic logic        ll = nvr_ll;
            automatic logic        ul = nvr_ul;
            if (upd_acpi) begin
              ab = acpi_base_next;
              ae = acpi_en_next;
              si = sci_next;
            end
            if (op_q == OP_DEV_RST) begin
              ue = 1'b0;
              ll = 1'b0;
              ul = 1'b0;
              reset_type_bit <= 1'b0;
            end else if (upd_nvr) begin
              ue = md8[2];
              ll = nvr_ll | md8[3];
              ul = nvr_ul | md8[4];
            end
            if (op_q == OP_RP_WR && !data_q[2]) reset_type_bit <= data_q[1];
            acpi_base_reg   <= ab;
            acpi_enable_reg <= ae;
            sci_irq_reg     <= si;
            nvr_ue          <= ue;
            nvr_ll          <= ll;
            nvr_ul          <= ul;
            // result register
            out_valid            <= 1'b1;
            read_data            <= (op_q == OP_CFG_RD) ? rd_acc :
                                    (op_q == OP_RP_RD) ? {30'b0, reset_type_bit, 1'b0} : 32'b0;
            route_irq            <= (op_q == OP_ROUTE) ? route_of(route_byte, idx_q) : 5'd0;
            acpi_base            <= ab;
            acpi_enabled         <= ae;
            sci_irq              <= si;
            upper_nvr_enabled    <= ue;
            lower_nvr_locked     <= ll;
            upper_nvr_locked     <= ul;
            system_reset_request <= (op_q == OP_RP_WR) && data_q[2];
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the pipe is drained whenever a new request can be taken
  a_drained: assert property (@(posedge clk) disable iff (rst) in_ready |-> !p_valid)
    else $error("pipe not drained at idle");
  // a read never lands on the byte being written back in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && rd_en && state == ST_XFER) |-> (cfg_waddr != rd_addr))
    else $error("read and write hit the same config byte");
  // the lower NVR lock only drops on a device reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    (nvr_ll && !(fin_go && op_q == OP_DEV_RST)) |=> nvr_ll)
    else $error("lower nvr lock dropped");
`endif

endmodule
